/* src/slcp_pkg.sv */
// ----------------------------------------------------------------------------
// slcp_pkg: shared types and constants of the serial load command parser
// Command codes between the parser front end and the executor, result codes
// and header layout constants.
// ----------------------------------------------------------------------------
package slcp_pkg;

    // header layout
    localparam logic [3:0] HDR_LEN  = 4'd12;
    localparam logic [3:0] JUMP_LEN = 4'd8;
    localparam logic [3:0] TAG_LEN  = 4'd4;

    // tag characters
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_J = 8'h4A;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_P = 8'h50;

    // command queue depth
    localparam int unsigned CMDQ_DEPTH = 2;

    // output tdata width, fields padded to whole bytes
    localparam int unsigned OUT_TDATA_W = 48;

    // result action codes
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_JUMP  = 2'd2
    } t_action;

    // command kinds from front end to executor
    typedef enum logic [1:0] {
        CMD_NOP    = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_BRANCH = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] addr;
        logic [7:0]  data;
    } t_cmd;

endpackage

/* src/slcp_front.sv */
// ----------------------------------------------------------------------------
// slcp_front: byte classifier of the serial load command parser
// Collects header bytes, decodes DATA and JUMP tags, tracks the data byte
// count and turns every received byte into one command for the executor.
// ----------------------------------------------------------------------------
module slcp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    input  logic             i_full,
    output slcp_pkg::t_cmd   o_cmd
);

    logic [7:0]  r_hdr [12];
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_in_data, n_in_data;
    logic [31:0] r_remain, n_remain;

    logic [7:0]  view [12];
    logic [3:0]  idx;
    logic [31:0] rem_left;
    logic        tag_data, tag_jump;
    slcp_pkg::t_cmd cmd;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_cmd   = cmd;

    // header bytes as they stand with the current beat written in
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            view[k] = (!r_in_data && r_hdr_cnt == 4'(k)) ? i_byte : r_hdr[k];
        end
    end

    assign tag_data = view[0] == slcp_pkg::CH_D && view[1] == slcp_pkg::CH_A &&
                      view[2] == slcp_pkg::CH_T && view[3] == slcp_pkg::CH_A;
    assign tag_jump = view[0] == slcp_pkg::CH_J && view[1] == slcp_pkg::CH_U &&
                      view[2] == slcp_pkg::CH_M && view[3] == slcp_pkg::CH_P;

    // classify the beat and compute next parser state
    always_comb begin
        n_in_data = r_in_data;
        n_hdr_cnt = r_hdr_cnt;
        n_remain  = r_remain;
        idx       = r_hdr_cnt;
        rem_left  = r_remain;
        cmd.kind  = slcp_pkg::CMD_NOP;
        cmd.addr  = '0;
        cmd.data  = '0;
        if (r_in_data) begin
            if (r_remain != 32'd0) begin
                cmd.kind = slcp_pkg::CMD_WRITE;
                cmd.data = i_byte;
                rem_left = r_remain - 32'd1;
            end
            n_remain = rem_left;
            if (rem_left == 32'd0) begin
                n_in_data = 1'b0;
                n_hdr_cnt = '0;
            end
        end else begin
            if (r_hdr_cnt < slcp_pkg::HDR_LEN) begin
                idx = r_hdr_cnt + 4'd1;
            end else begin
                idx = '0;
            end
            n_hdr_cnt = idx;
            if (idx >= slcp_pkg::TAG_LEN) begin
                if (tag_data) begin
                    if (idx >= slcp_pkg::HDR_LEN) begin
                        n_remain  = {view[7], view[6], view[5], view[4]};
                        cmd.kind  = slcp_pkg::CMD_LOAD;
                        cmd.addr  = {view[11], view[10], view[9], view[8]};
                        n_in_data = 1'b1;
                        n_hdr_cnt = '0;
                    end
                end else if (tag_jump) begin
                    if (idx >= slcp_pkg::JUMP_LEN) begin
                        cmd.kind  = slcp_pkg::CMD_BRANCH;
                        cmd.addr  = {view[7], view[6], view[5], view[4]};
                        n_hdr_cnt = '0;
                    end
                end else begin
                    n_hdr_cnt = '0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_data <= 1'b0;
            r_hdr_cnt <= '0;
            r_remain  <= '0;
        end else if (o_push) begin
            r_in_data <= n_in_data;
            r_hdr_cnt <= n_hdr_cnt;
            r_remain  <= n_remain;
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (o_push && !r_in_data && r_hdr_cnt < slcp_pkg::HDR_LEN) begin
            r_hdr[r_hdr_cnt] <= i_byte;
        end
    end

    // header count stays within the header length
    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt <= slcp_pkg::HDR_LEN)
        else $error("header count out of range");

    // no header bytes are pending while data bytes are written
    a_data_hdr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_data |-> r_hdr_cnt == 4'd0)
        else $error("header count not cleared in data phase");

    // a load command always enters the data phase
    a_load_enters_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && cmd.kind == slcp_pkg::CMD_LOAD) |=> r_in_data)
        else $error("load command without data phase");

endmodule

/* src/slcp_cmdq.sv */
// ----------------------------------------------------------------------------
// slcp_cmdq: command queue between parser front end and executor
// Small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module slcp_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slcp_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output slcp_pkg::t_cmd   o_cmd
);

    localparam int unsigned PtrW = $clog2(slcp_pkg::CMDQ_DEPTH);

    slcp_pkg::t_cmd         r_mem [slcp_pkg::CMDQ_DEPTH];
    logic [PtrW-1:0]        r_wptr, r_rptr;
    logic [PtrW:0]          r_count;

    assign o_full  = r_count == (PtrW + 1)'(slcp_pkg::CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrW'(slcp_pkg::CMDQ_DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PtrW'(slcp_pkg::CMDQ_DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PtrW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PtrW + 1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // fill level never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PtrW + 1)'(slcp_pkg::CMDQ_DEPTH))
        else $error("command queue overflow");

endmodule

/* src/slcp_exec.sv */
// ----------------------------------------------------------------------------
// slcp_exec: command executor of the serial load command parser
// Holds the write pointer, turns commands into result beats and keeps the
// result in an output register.
// ----------------------------------------------------------------------------
module slcp_exec #(
    parameter int unsigned ADDRESS_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  slcp_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_action,
    output logic [31:0]      o_addr,
    output logic [7:0]       o_data
);

    // pointer width: address width held to 32 bits
    localparam int unsigned PtrW = (ADDRESS_WIDTH < 32) ? ADDRESS_WIDTH : 32;

    logic [PtrW-1:0] r_ptr;
    logic            r_valid;
    logic [1:0]      r_action;
    logic [31:0]     r_addr;
    logic [7:0]      r_data;

    assign o_pop    = i_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_addr   = r_addr;
    assign o_data   = r_data;

    // write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (o_pop) begin
            case (i_cmd.kind)
                slcp_pkg::CMD_LOAD:  r_ptr <= i_cmd.addr[PtrW-1:0];
                slcp_pkg::CMD_WRITE: r_ptr <= r_ptr + PtrW'(1);
                default:             r_ptr <= r_ptr;
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_cmd.kind) inside
                slcp_pkg::CMD_WRITE: begin
                    r_action <= slcp_pkg::ACT_WRITE;
                    r_addr   <= 32'(r_ptr);
                    r_data   <= i_cmd.data;
                end
                slcp_pkg::CMD_BRANCH: begin
                    r_action <= slcp_pkg::ACT_JUMP;
                    r_addr   <= 32'(i_cmd.addr[PtrW-1:0]);
                    r_data   <= '0;
                end
                slcp_pkg::CMD_NOP, slcp_pkg::CMD_LOAD: begin
                    r_action <= slcp_pkg::ACT_NONE;
                    r_addr   <= '0;
                    r_data   <= '0;
                end
                default: begin
                    r_action <= slcp_pkg::ACT_NONE;
                    r_addr   <= '0;
                    r_data   <= '0;
                end
            endcase
        end
    end

    // a load sets the pointer to the masked start address
    a_load_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == slcp_pkg::CMD_LOAD) |=>
            r_ptr == $past(i_cmd.addr[PtrW-1:0]))
        else $error("pointer load mismatch");

    // each write advances the pointer by one
    a_write_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == slcp_pkg::CMD_WRITE) |=>
            r_ptr == $past(r_ptr) + PtrW'(1))
        else $error("pointer did not advance on write");

endmodule

/* src/serial_load_command_parser_core.sv */
// ----------------------------------------------------------------------------
// serial_load_command_parser_core: serial loader command parser, top level
// An accepted beat passes through the command queue and the output register.
// Throughput: one byte per cycle while the command queue is not full.
// A two-entry command queue and an output register decouple input and output.
// Reset: synchronous active low; clears parser state, pointer, queue and output valid.
// Header byte store is not reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module serial_load_command_parser_core #(
    parameter int unsigned ADDRESS_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [slcp_pkg::OUT_TDATA_W-1:0] o_m_tdata
    // o_m_tdata: [1:0] action, [33:2] target_address, [41:34] write_data,
    // [47:42] zero
);

    logic           push, full, q_valid, pop;
    slcp_pkg::t_cmd f_cmd, q_cmd;
    logic [1:0]     action;
    logic [31:0]    addr;
    logic [7:0]     data;

    // byte classifier
    slcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .o_push  (push),
        .i_full  (full),
        .o_cmd   (f_cmd)
    );

    // command queue
    slcp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (q_cmd)
    );

    // executor and output register
    slcp_exec #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (pop),
        .i_cmd    (q_cmd),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_action (action),
        .o_addr   (addr),
        .o_data   (data)
    );

    // pack result fields
    assign o_m_tdata = {6'd0, data, addr, action};

endmodule
